// ===== sv/taylor_sin_cos_tan_defines.svh =====
// Assertion macros shared by the taylor_sin_cos_tan RTL files.
// Needs signals named clock and reset in the module that uses them.
`ifndef TAYLOR_SIN_COS_TAN_DEFINES_SVH
`define TAYLOR_SIN_COS_TAN_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSCT_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSCT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tsct_pkg.sv =====
// Shared constants, widths and types for the Taylor sine/cosine/tangent block.
// No dependencies.
package tsct_pkg;

   localparam int FRAC_BITS = 24;
   localparam int MAX_TERMS_DEF = 32;
   localparam int ANG_W = 32;
   localparam int Y_W = 27;
   localparam int T_W = 27;
   localparam int X2_W = 27;
   localparam int ACC_W = 34;
   localparam int TC_W = 6;
   localparam logic [TC_W-1:0] TC_RESET = 6'd8;

   localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
   localparam logic [63:0] PI_W =
      (PI_Q61 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
   localparam logic [63:0] TWO_PI_W =
      (PI_Q61 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
   localparam logic [63:0] HALF_PI_W =
      (PI_Q61 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
   localparam logic [ANG_W-1:0] PI_FX = PI_W[ANG_W-1:0];
   localparam logic [ANG_W-1:0] TWO_PI_FX = TWO_PI_W[ANG_W-1:0];
   localparam logic [ANG_W-1:0] HALF_PI_FX = HALF_PI_W[ANG_W-1:0];
   localparam logic [ANG_W-1:0] ONE_FX = ANG_W'(1) << FRAC_BITS;

   // Magnitudes reach 2^31, below 32 times 2*pi, so five subtract steps suffice.
   localparam int RED_STEPS = 5;

   // Divider chain: one quotient bit per cell.
   localparam int DIV_Q_W = 33;
   localparam int DIV_R_W = 32;
   localparam int DIVD_W = ANG_W + FRAC_BITS;

   localparam logic [1:0] MODE_COS = 2'd0;
   localparam logic [1:0] MODE_SIN = 2'd1;
   localparam logic [1:0] MODE_TAN = 2'd2;

   typedef struct packed {
      logic               valid;
      logic [DIV_R_W-1:0] rem;
      logic [DIV_Q_W-1:0] low;
      logic [DIV_R_W-1:0] dsr;
   } div_slot_type;

endpackage

// ===== sv/tsct_div_cell.sv =====
// One restoring-division cell: shifts in one dividend bit, emits one quotient bit.
// Depends on tsct_pkg.
module tsct_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tsct_pkg::div_slot_type slot_i,
   output tsct_pkg::div_slot_type slot_o
);
   import tsct_pkg::*;

   logic [DIV_R_W:0] shifted;
   logic [DIV_R_W:0] diff;
   logic             ge;
   div_slot_type     slot_ff;

   always_comb begin
      shifted = {slot_i.rem, slot_i.low[DIV_Q_W-1]};
      diff    = shifted - {1'b0, slot_i.dsr};
      ge      = shifted >= {1'b0, slot_i.dsr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_i.valid;
      end
      slot_ff.rem <= ge ? diff[DIV_R_W-1:0] : shifted[DIV_R_W-1:0];
      slot_ff.low <= {slot_i.low[DIV_Q_W-2:0], ge};
      slot_ff.dsr <= slot_i.dsr;
   end

   assign slot_o = slot_ff;

endmodule

// ===== sv/tsct_div_chain.sv =====
// Row of division cells; the quotient is taken from the last cell.
// Depends on tsct_pkg, tsct_div_cell and the assertion macro header.
`include "taylor_sin_cos_tan_defines.svh"

module tsct_div_chain (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [tsct_pkg::DIVD_W-1:0]  in_dividend,
   input  logic [tsct_pkg::DIV_R_W-1:0] in_divisor,
   output logic                         out_valid,
   output logic [tsct_pkg::DIV_Q_W-1:0] out_quotient
);
   import tsct_pkg::*;

   div_slot_type       slot [0:DIV_Q_W];
   logic [DIV_Q_W-1:0] vld;

   // The high dividend bits start as the partial remainder; the caller keeps them
   // below the divisor.
   assign slot[0] = {in_valid, DIV_R_W'(in_dividend[DIVD_W-1:DIV_Q_W]),
                     in_dividend[DIV_Q_W-1:0], in_divisor};

   for (genvar i = 0; i < DIV_Q_W; i++) begin : g_cell
      tsct_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .slot_i (slot[i]),
         .slot_o (slot[i+1])
      );
      assign vld[i] = slot[i+1].valid;
   end

   assign out_valid    = slot[DIV_Q_W].valid;
   assign out_quotient = slot[DIV_Q_W].low;

   `TSCT_ASSERT(a_one_in_flight, 1'b1, $onehot0(vld), "more than one item in divider")

endmodule

// ===== sv/taylor_sin_cos_tan.sv =====
// Top level: angle reduction, Taylor series sequencer and tangent quotient.
// Depends on tsct_pkg, tsct_div_chain and the assertion macro header.
//
//   channel   ports                                  handshake
//   request   req_start, req_angle, req_mode, busy   taken when start and not busy
//   response  rsp_valid, rsp_value, rsp_overflow     one-cycle strobe, no stall
//   config    csr_we, csr_wdata                      written when csr_we is high
//
// Sine or cosine runs one multiply and one division pass for each of T = 2 * floor(N / 2)
// terms, with N the term count clamped to MAX_TERMS; tangent runs both series and then
// one more division unless the result saturates. Each term is one multiply and one pass through
// the 33-cell divider chain. Reset is synchronous and restores term_count to 8.
// Results cannot be stalled; busy falls in the cycle the result strobe is shown.
`include "taylor_sin_cos_tan_defines.svh"

module taylor_sin_cos_tan #(
   parameter int MAX_TERMS = tsct_pkg::MAX_TERMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_start,
   input  logic signed [tsct_pkg::ANG_W-1:0] req_angle,
   input  logic [1:0]                        req_mode,
   output logic                              busy,
   output logic                              rsp_valid,
   output logic signed [tsct_pkg::ANG_W-1:0] rsp_value,
   output logic                              rsp_overflow,
   input  logic                              csr_we,
   input  logic [tsct_pkg::TC_W-1:0]         csr_wdata
);
   import tsct_pkg::*;

   localparam int LIM_W = $clog2(MAX_TERMS + 1);
   localparam int J_W   = $clog2(MAX_TERMS + 2);
   localparam int A_W   = J_W + 1;
   localparam int RC_W  = $clog2(RED_STEPS);
   localparam int PRE_SH = DIV_Q_W - FRAC_BITS;

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b000000000001,
      ST_REDUCE  = 12'b000000000010,
      ST_FOLD    = 12'b000000000100,
      ST_SQUARE  = 12'b000000001000,
      ST_CHECK   = 12'b000000010000,
      ST_MUL     = 12'b000000100000,
      ST_DIVGO   = 12'b000001000000,
      ST_DIVWAIT = 12'b000010000000,
      ST_FNDONE  = 12'b000100000000,
      ST_TAN     = 12'b001000000000,
      ST_TANWAIT = 12'b010000000000,
      ST_NONE    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [TC_W-1:0]      term_count_ff;
   logic [LIM_W-1:0]     lim_ff, lim_in;
   logic [1:0]           mode_ff;
   logic                 neg_ff;
   logic                 want_sin_ff;
   logic [ANG_W-1:0]     x_ff;
   logic [ANG_W-1:0]     m_ff;
   logic [RC_W-1:0]      rcnt_ff;
   logic [Y_W-1:0]       y_ff;
   logic                 flip_ff;
   logic [X2_W-1:0]      x2_ff;
   logic [T_W-1:0]       t_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [J_W-1:0]       j_ff;
   logic [DIV_R_W-1:0]   div_ff;
   logic [T_W+X2_W-1:0]  prod_ff;
   logic signed [ANG_W-1:0] s_ff, c_ff;
   logic                 qneg_ff;
   logic                 rsp_valid_ff;
   logic signed [ANG_W-1:0] rsp_value_ff;
   logic                 rsp_overflow_ff;

   // Datapath helpers
   logic [ANG_W-1:0]     mag;
   logic [ANG_W-1:0]     x_less_pi;
   logic [ANG_W-1:0]     y_w;
   logic                 flip_w;
   logic [2*Y_W-1:0]     ysq;
   logic [2*Y_W-1:0]     ysq_sh;
   logic [J_W-1:0]       n_w;
   logic [A_W-1:0]       fa, fb;
   logic [2*A_W-1:0]     dprod;
   logic signed [ACC_W-1:0] q_ext;
   logic signed [ACC_W-1:0] r_w;
   logic signed [ANG_W-1:0] sat_w;
   logic [ANG_W-1:0]     sm, cm;
   logic                 tan_qneg;
   logic                 tan_big;
   logic                 div_go;
   logic [DIVD_W-1:0]    div_dividend;
   logic [DIV_R_W-1:0]   div_divisor;
   logic                 div_done;
   logic [DIV_Q_W-1:0]   div_q;

   tsct_div_chain u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (div_go),
      .in_dividend  (div_dividend),
      .in_divisor   (div_divisor),
      .out_valid    (div_done),
      .out_quotient (div_q)
   );

   always_comb begin
      mag = ANG_W'(0) - req_angle;
      if (!req_angle[ANG_W-1]) begin
         mag = req_angle;
      end

      // Fold the reduced angle into the first quadrant.
      x_less_pi = x_ff - PI_FX;
      if (x_ff >= PI_FX) begin
         if (x_less_pi >= HALF_PI_FX) begin
            y_w    = TWO_PI_FX - x_ff;
            flip_w = want_sin_ff;
         end else begin
            y_w    = x_less_pi;
            flip_w = 1'b1;
         end
      end else if (x_ff >= HALF_PI_FX) begin
         y_w    = PI_FX - x_ff;
         flip_w = !want_sin_ff;
      end else begin
         y_w    = x_ff;
         flip_w = 1'b0;
      end
      if (want_sin_ff && neg_ff) begin
         flip_w = !flip_w;
      end

      ysq    = y_ff * y_ff;
      ysq_sh = ysq >> FRAC_BITS;

      // Term j belongs to the pass whose odd index is j or j - 1.
      n_w = j_ff[0] ? j_ff : j_ff - J_W'(1);
      fa  = want_sin_ff ? {j_ff, 1'b0} : {j_ff, 1'b0} - A_W'(1);
      fb  = fa + A_W'(1);
      dprod = (2*A_W)'(fa) * (2*A_W)'(fb);

      q_ext = $signed({{(ACC_W-T_W){1'b0}}, div_q[T_W-1:0]});

      r_w = flip_ff ? -acc_ff : acc_ff;
      if (!r_w[ACC_W-1] && (r_w[ACC_W-2:ANG_W-1] != '0)) begin
         sat_w = {1'b0, {(ANG_W-1){1'b1}}};
      end else if (r_w[ACC_W-1] && (r_w[ACC_W-2:ANG_W-1] != '1)) begin
         sat_w = {1'b1, {(ANG_W-1){1'b0}}};
      end else begin
         sat_w = r_w[ANG_W-1:0];
      end

      sm = s_ff[ANG_W-1] ? ANG_W'(0) - s_ff : s_ff;
      cm = c_ff[ANG_W-1] ? ANG_W'(0) - c_ff : c_ff;
      tan_qneg = s_ff[ANG_W-1] ^ c_ff[ANG_W-1];
      // The quotient would need more than DIV_Q_W bits.
      tan_big  = ANG_W'(sm[ANG_W-1:PRE_SH]) >= cm;

      div_go       = (state_ff == ST_DIVGO) ||
                     ((state_ff == ST_TAN) && (c_ff != '0) && !tan_big);
      div_dividend = DIVD_W'(prod_ff >> FRAC_BITS);
      div_divisor  = div_ff;
      if (state_ff == ST_TAN) begin
         div_dividend = {sm, {FRAC_BITS{1'b0}}};
         div_divisor  = cm;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               state_in = (req_mode == MODE_COS || req_mode == MODE_SIN ||
                           req_mode == MODE_TAN) ? ST_REDUCE : ST_NONE;
            end
         end
         ST_REDUCE:  state_in = (rcnt_ff == '0) ? ST_FOLD : ST_REDUCE;
         ST_FOLD:    state_in = ST_SQUARE;
         ST_SQUARE:  state_in = ST_CHECK;
         ST_CHECK:   state_in = (n_w < J_W'(lim_ff)) ? ST_MUL : ST_FNDONE;
         ST_MUL:     state_in = ST_DIVGO;
         ST_DIVGO:   state_in = ST_DIVWAIT;
         ST_DIVWAIT: state_in = div_done ? ST_CHECK : ST_DIVWAIT;
         ST_FNDONE: begin
            if (mode_ff == MODE_TAN) begin
               state_in = want_sin_ff ? ST_FOLD : ST_TAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TAN:     state_in = div_go ? ST_TANWAIT : ST_IDLE;
         ST_TANWAIT: state_in = div_done ? ST_IDLE : ST_TANWAIT;
         ST_NONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lim_in = LIM_W'(term_count_ff);
      if (32'(term_count_ff) > MAX_TERMS) begin
         lim_in = LIM_W'(MAX_TERMS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         term_count_ff <= TC_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= ((state_ff == ST_FNDONE) && (mode_ff != MODE_TAN)) ||
                         ((state_ff == ST_TAN) && !div_go) ||
                         ((state_ff == ST_TANWAIT) && div_done) ||
                         (state_ff == ST_NONE);
         if (csr_we) begin
            term_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            mode_ff     <= req_mode;
            neg_ff      <= req_angle[ANG_W-1];
            want_sin_ff <= (req_mode != MODE_COS);
            x_ff        <= mag;
            m_ff        <= TWO_PI_FX << (RED_STEPS - 1);
            rcnt_ff     <= RC_W'(RED_STEPS - 1);
            lim_ff      <= lim_in;
         end
         ST_REDUCE: begin
            if (x_ff >= m_ff) begin
               x_ff <= x_ff - m_ff;
            end
            m_ff    <= m_ff >> 1;
            rcnt_ff <= rcnt_ff - RC_W'(1);
         end
         ST_FOLD: begin
            y_ff    <= y_w[Y_W-1:0];
            flip_ff <= flip_w;
         end
         ST_SQUARE: begin
            x2_ff  <= ysq_sh[X2_W-1:0];
            t_ff   <= want_sin_ff ? y_ff : ONE_FX[T_W-1:0];
            acc_ff <= want_sin_ff ? $signed(ACC_W'(y_ff)) : $signed(ACC_W'(ONE_FX));
            j_ff   <= J_W'(1);
         end
         ST_CHECK: begin
            div_ff <= DIV_R_W'(dprod);
         end
         ST_MUL: begin
            prod_ff <= t_ff * x2_ff;
         end
         ST_DIVWAIT: begin
            if (div_done) begin
               t_ff   <= div_q[T_W-1:0];
               acc_ff <= j_ff[0] ? acc_ff - q_ext : acc_ff + q_ext;
               j_ff   <= j_ff + J_W'(1);
            end
         end
         ST_FNDONE: begin
            if (mode_ff == MODE_TAN) begin
               if (want_sin_ff) begin
                  s_ff        <= sat_w;
                  want_sin_ff <= 1'b0;
               end else begin
                  c_ff <= sat_w;
               end
            end else begin
               rsp_value_ff    <= sat_w;
               rsp_overflow_ff <= 1'b0;
            end
         end
         ST_TAN: begin
            qneg_ff <= tan_qneg;
            if (c_ff == '0) begin
               rsp_value_ff    <= s_ff[ANG_W-1] ? {1'b1, {(ANG_W-1){1'b0}}}
                                                : {1'b0, {(ANG_W-1){1'b1}}};
               rsp_overflow_ff <= 1'b1;
            end else if (tan_big) begin
               rsp_value_ff    <= tan_qneg ? {1'b1, {(ANG_W-1){1'b0}}}
                                           : {1'b0, {(ANG_W-1){1'b1}}};
               rsp_overflow_ff <= 1'b1;
            end
         end
         ST_TANWAIT: begin
            if (div_done) begin
               if (!qneg_ff && (div_q > DIV_Q_W'({1'b0, {(ANG_W-1){1'b1}}}))) begin
                  rsp_value_ff    <= {1'b0, {(ANG_W-1){1'b1}}};
                  rsp_overflow_ff <= 1'b1;
               end else if (qneg_ff && (div_q > DIV_Q_W'({1'b1, {(ANG_W-1){1'b0}}}))) begin
                  rsp_value_ff    <= {1'b1, {(ANG_W-1){1'b0}}};
                  rsp_overflow_ff <= 1'b1;
               end else begin
                  rsp_value_ff    <= qneg_ff ? ANG_W'(0) - div_q[ANG_W-1:0]
                                             : div_q[ANG_W-1:0];
                  rsp_overflow_ff <= 1'b0;
               end
            end
         end
         ST_NONE: begin
            rsp_value_ff    <= '0;
            rsp_overflow_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_overflow = rsp_overflow_ff;

   `TSCT_ASSERT_NXT(a_accept_goes_busy, req_start && !busy, busy, "accepted item did not start")
   `TSCT_ASSERT(a_rsp_after_work, rsp_valid, $past(busy), "result without an item in work")
   `TSCT_ASSERT(a_div_when_waiting, div_done, state_ff == ST_DIVWAIT || state_ff == ST_TANWAIT, "quotient arrived while not waiting")

endmodule
